// ===== hw/rtl/rqi_pkg.sv =====
// ----------------------------------------------------------------------------
// rqi_pkg: shared types and constants for the ray/quad intersection pipeline
// Coordinates are signed Q10.10 in CB bits. Every width below follows from CB
// and from the bounds of the exact integer triangle test.
// ----------------------------------------------------------------------------
package rqi_pkg;

    localparam int CB    = 20;            // coordinate bits
    localparam int WE    = CB + 1;        // corner difference
    localparam int WP    = 2 * WE;        // one cross product term
    localparam int WX    = WP + 1;        // cross product component
    localparam int WS    = WX + WE + 2;   // dot product sum
    localparam int WQ    = WS - 2;        // magnitude of QdN and DdN
    localparam int WH    = WQ / 2;        // half of a magnitude, for split products
    localparam int WHD   = WH + CB;       // half magnitude times |d|
    localparam int WM    = WQ + CB;       // QdN times |d|
    localparam int WR    = WM + 4;        // division remainder
    localparam int WDD   = 2 * CB;        // one square of a direction component
    localparam int WD2   = 2 * CB + 1;    // |d| squared
    localparam int WSQ   = 2 * WQ;        // square of a magnitude
    localparam int NCH   = WSQ / WH;      // chunks of a square for the N product
    localparam int WNP   = WH + WD2;      // one chunk product
    localparam int WN    = WSQ + WD2 + 3; // radicand and running remainder
    localparam int QB    = CB + 1;        // quotient bits kept before saturation
    localparam int SB    = CB + 2;        // bits of the doubled distance
    localparam int NIT   = SB;            // iteration stages
    localparam int NV    = 9 + NIT;       // stages ahead of the output register
    localparam int IN_W  = ((6 * CB + 7) / 8) * 8;
    localparam int OUT_W = ((4 * CB + 7) / 8) * 8;
    localparam int CFG_IW = 2;

    // next and previous axis, for cross products
    localparam int NX1 [3] = '{1, 2, 0};
    localparam int NX2 [3] = '{2, 0, 1};
    // corners a, b, c of each triangle
    localparam int TRI_V [2][3] = '{'{0, 2, 1}, '{1, 2, 3}};

    typedef logic signed [CB-1:0]  t_coord;
    typedef logic signed [WE-1:0]  t_edge;
    typedef logic signed [WP-1:0]  t_prod;
    typedef logic signed [WX-1:0]  t_cross;
    typedef logic signed [WS-1:0]  t_sum;
    typedef logic signed [WDD-1:0] t_dsq;
    typedef logic signed [QB+1:0]  t_pt;

    typedef enum logic [CFG_IW-1:0] {
        REG_CORNER_ZERO  = 2'd0,
        REG_CORNER_ONE   = 2'd1,
        REG_CORNER_TWO   = 2'd2,
        REG_CORNER_THREE = 2'd3
    } t_cfg_reg;

    // state carried through the divide and root iterations
    typedef struct packed {
        logic              hit;
        logic [2:0][CB-1:0] o;
        logic [2:0]        neg;
        logic [2:0]        ovf;
        logic [2:0][WR-1:0] rem;
        logic [2:0][QB-1:0] quo;
        logic [WR-1:0]     den;
        logic [WN-1:0]     r;
        logic [WN-1:0]     sd;
        logic [SB-1:0]     s;
        logic [WSQ-1:0]    dsq;
    } t_iter;

    function automatic t_coord corner_coord(input logic [3*CB-1:0] c, input int k);
        return t_coord'(c[k*CB +: CB]);
    endfunction

endpackage

// ===== hw/rtl/ray_quad_intersection.sv =====
// ----------------------------------------------------------------------------
// ray_quad_intersection: ray against a two-triangle quad, one ray per clock unless the output stalls
// Exact integer barycentric test on both triangles, then hit point and
// distance in Q10.10 with saturation.
// ----------------------------------------------------------------------------
// Usage
//   Config: write the four corners (x, y, z packed, 20 bits each) through the
//   i_cfg_* channel, index 0..3, while no ray is in flight. o_cfg_ready is
//   always high.
//   Input: one ray per s_axis beat, origin x, y, z then direction x, y, z.
//   Output: one m_axis beat per ray, in order: hit flag in tuser, point x, y,
//   z and distance in tdata; all zero on a miss.
//   Throughput: one ray per cycle while the output is not stalled. The
//   depth is set by the quotient and root recurrences, one bit per stage
//   (21 quotient bits, 22 root bits) behind nine arithmetic stages.
//   Reset clears every stage valid and the corners; no clearing pass.
//   Stall: the whole pipeline holds while the output beat waits; s_axis_tready
//   drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_quad_intersection
    import rqi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [3*CB-1:0]     i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // point_x, point_y, point_z, distance
    output logic [OUT_W-1:0]    m_axis_tdata,
    // hit
    output logic [0:0]          m_axis_tuser
);

    logic              en;
    logic [3*CB-1:0]   r_corner [4];
    logic [NV-1:0]     r_v;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_tdata;
    logic              r_out_hit;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;
    assign m_axis_tuser  = r_out_hit;

    // corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 4; c++) r_corner[c] <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CORNER_ZERO:  r_corner[0] <= i_cfg_data;
                REG_CORNER_ONE:   r_corner[1] <= i_cfg_data;
                REG_CORNER_TWO:   r_corner[2] <= i_cfg_data;
                REG_CORNER_THREE: r_corner[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[NV-2:0], s_axis_tvalid};
            r_out_valid <= r_v[NV-1];
        end
    end

    // ---------------- stage 1: corner differences
    t_coord w_in_o [3], w_in_d [3];
    t_edge  n_e1_p1 [2][3], n_e2_p1 [2][3], n_df_p1 [2][3];
    t_edge  r_e1_p1 [2][3], r_e2_p1 [2][3], r_df_p1 [2][3];
    t_coord r_o_p1 [3], r_d_p1 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_in_o[k] = t_coord'(s_axis_tdata[k*CB +: CB]);
            w_in_d[k] = t_coord'(s_axis_tdata[(3+k)*CB +: CB]);
        end
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < 3; k++) begin
                n_e1_p1[t][k] = t_edge'(corner_coord(r_corner[TRI_V[t][1]], k))
                              - t_edge'(corner_coord(r_corner[TRI_V[t][0]], k));
                n_e2_p1[t][k] = t_edge'(corner_coord(r_corner[TRI_V[t][2]], k))
                              - t_edge'(corner_coord(r_corner[TRI_V[t][0]], k));
                n_df_p1[t][k] = t_edge'(w_in_o[k])
                              - t_edge'(corner_coord(r_corner[TRI_V[t][0]], k));
            end
        end
    end

    // ---------------- stage 2: cross product terms (n, q x e2, e1 x q)
    t_prod       n_pa_p2 [2][3][3], n_pb_p2 [2][3][3];
    t_prod       r_pa_p2 [2][3][3], r_pb_p2 [2][3][3];
    t_edge       r_df_p2 [2][3];
    t_coord      r_o_p2 [3], r_d_p2 [3];
    logic [WDD-1:0] n_dd_p2 [3], r_dd_p2 [3];

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int k = 0; k < 3; k++) begin
                n_pa_p2[t][0][k] = t_prod'(r_e1_p1[t][NX1[k]]) * t_prod'(r_e2_p1[t][NX2[k]]);
                n_pb_p2[t][0][k] = t_prod'(r_e1_p1[t][NX2[k]]) * t_prod'(r_e2_p1[t][NX1[k]]);
                n_pa_p2[t][1][k] = t_prod'(r_df_p1[t][NX1[k]]) * t_prod'(r_e2_p1[t][NX2[k]]);
                n_pb_p2[t][1][k] = t_prod'(r_df_p1[t][NX2[k]]) * t_prod'(r_e2_p1[t][NX1[k]]);
                n_pa_p2[t][2][k] = t_prod'(r_e1_p1[t][NX1[k]]) * t_prod'(r_df_p1[t][NX2[k]]);
                n_pb_p2[t][2][k] = t_prod'(r_e1_p1[t][NX2[k]]) * t_prod'(r_df_p1[t][NX1[k]]);
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_dd_p2[k] = t_dsq'(r_d_p1[k]) * t_dsq'(r_d_p1[k]);
        end
    end

    // ---------------- stage 3: dot product terms (dn, x, y, q)
    t_cross         w_cr [2][3][3];
    t_sum           n_pd_p3 [2][4][3], r_pd_p3 [2][4][3];
    logic [WD2-1:0] n_d2_p3, r_d2_p3;
    t_coord         r_o_p3 [3], r_d_p3 [3];

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 3; k++) begin
                    w_cr[t][c][k] = t_cross'(r_pa_p2[t][c][k]) - t_cross'(r_pb_p2[t][c][k]);
                end
            end
            for (int k = 0; k < 3; k++) begin
                n_pd_p3[t][0][k] = t_sum'(r_d_p2[k]) * t_sum'(w_cr[t][0][k]);
                n_pd_p3[t][1][k] = t_sum'(r_d_p2[k]) * t_sum'(w_cr[t][1][k]);
                n_pd_p3[t][2][k] = t_sum'(r_d_p2[k]) * t_sum'(w_cr[t][2][k]);
                n_pd_p3[t][3][k] = t_sum'(r_df_p2[t][k]) * t_sum'(w_cr[t][0][k]);
            end
        end
        n_d2_p3 = WD2'(r_dd_p2[0]) + WD2'(r_dd_p2[1]) + WD2'(r_dd_p2[2]);
    end

    // ---------------- stage 4: dot product sums
    t_sum           n_s_p4 [2][4], r_s_p4 [2][4];
    logic [WD2-1:0] r_d2_p4;
    t_coord         r_o_p4 [3], r_d_p4 [3];

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            for (int j = 0; j < 4; j++) begin
                n_s_p4[t][j] = r_pd_p3[t][j][0] + r_pd_p3[t][j][1] + r_pd_p3[t][j][2];
            end
        end
    end

    // ---------------- stage 5: sign-normalised tests, first hit wins
    t_sum           w_adn [2], w_xv [2], w_yv [2], w_qv [2];
    logic           w_tneg [2], w_thit [2];
    logic           w_sel;
    logic           n_hit_p5, r_hit_p5;
    logic [WQ-1:0]  n_qm_p5, n_dm_p5, r_qm_p5, r_dm_p5;
    logic [WD2-1:0] r_d2_p5;
    t_coord         r_o_p5 [3], r_d_p5 [3];

    always_comb begin
        for (int t = 0; t < 2; t++) begin
            w_tneg[t] = r_s_p4[t][0][WS-1];
            w_adn[t]  = w_tneg[t] ? -r_s_p4[t][0] : r_s_p4[t][0];
            w_xv[t]   = w_tneg[t] ? -r_s_p4[t][1] : r_s_p4[t][1];
            w_yv[t]   = w_tneg[t] ? -r_s_p4[t][2] : r_s_p4[t][2];
            w_qv[t]   = w_tneg[t] ? r_s_p4[t][3] : -r_s_p4[t][3];
            w_thit[t] = (r_s_p4[t][0] != '0) && !w_xv[t][WS-1] && !w_yv[t][WS-1]
                     && !((w_xv[t] + w_yv[t]) > w_adn[t]) && !w_qv[t][WS-1];
        end
        w_sel    = !w_thit[0];
        n_hit_p5 = w_thit[0] || w_thit[1];
        n_qm_p5  = w_qv[w_sel][WQ-1:0];
        n_dm_p5  = w_adn[w_sel][WQ-1:0];
    end

    // ---------------- stage 6: split products Q*|d|, Q^2, D^2
    logic [CB-1:0]  w_absd [3];
    logic [WHD-1:0] n_pml_p6 [3], n_pmh_p6 [3], r_pml_p6 [3], r_pmh_p6 [3];
    logic [WQ-1:0]  n_sq_p6 [2][3], r_sq_p6 [2][3];
    logic [WQ-1:0]  r_dm_p6;
    logic [2:0]     n_neg_p6, r_neg_p6;
    logic           r_hit_p6;
    logic [WD2-1:0] r_d2_p6;
    t_coord         r_o_p6 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_neg_p6[k] = r_d_p5[k][CB-1];
            w_absd[k]   = n_neg_p6[k] ? (CB'(0) - $unsigned(r_d_p5[k])) : $unsigned(r_d_p5[k]);
            n_pml_p6[k] = WHD'(r_qm_p5[WH-1:0]) * WHD'(w_absd[k]);
            n_pmh_p6[k] = WHD'(r_qm_p5[WQ-1:WH]) * WHD'(w_absd[k]);
        end
        n_sq_p6[0][0] = WQ'(r_qm_p5[WQ-1:WH]) * WQ'(r_qm_p5[WQ-1:WH]);
        n_sq_p6[0][1] = WQ'(r_qm_p5[WQ-1:WH]) * WQ'(r_qm_p5[WH-1:0]);
        n_sq_p6[0][2] = WQ'(r_qm_p5[WH-1:0]) * WQ'(r_qm_p5[WH-1:0]);
        n_sq_p6[1][0] = WQ'(r_dm_p5[WQ-1:WH]) * WQ'(r_dm_p5[WQ-1:WH]);
        n_sq_p6[1][1] = WQ'(r_dm_p5[WQ-1:WH]) * WQ'(r_dm_p5[WH-1:0]);
        n_sq_p6[1][2] = WQ'(r_dm_p5[WH-1:0]) * WQ'(r_dm_p5[WH-1:0]);
    end

    // ---------------- stage 7: recombine products
    logic [WM-1:0]  n_m_p7 [3], r_m_p7 [3];
    logic [WSQ-1:0] n_sq2_p7 [2], r_sq2_p7 [2];
    logic [WQ-1:0]  r_dm_p7;
    logic [2:0]     r_neg_p7;
    logic           r_hit_p7;
    logic [WD2-1:0] r_d2_p7;
    t_coord         r_o_p7 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_m_p7[k] = (WM'(r_pmh_p6[k]) << WH) + WM'(r_pml_p6[k]);
        end
        for (int i = 0; i < 2; i++) begin
            n_sq2_p7[i] = (WSQ'(r_sq_p6[i][0]) << WQ) + (WSQ'(r_sq_p6[i][1]) << (WH + 1))
                        + WSQ'(r_sq_p6[i][2]);
        end
    end

    // ---------------- stage 8: divide set-up, radicand chunk products
    logic [WR-1:0]  w_num [3];
    logic [WR-1:0]  n_rem_p8 [3], r_rem_p8 [3];
    logic [WR-1:0]  n_den_p8, r_den_p8;
    logic [2:0]     n_ovf_p8, r_ovf_p8;
    logic [WNP-1:0] n_np_p8 [NCH], r_np_p8 [NCH];
    logic [WSQ-1:0] r_dsq_p8;
    logic [2:0]     r_neg_p8;
    logic           r_hit_p8;
    t_coord         r_o_p8 [3];

    always_comb begin
        n_den_p8 = WR'(r_dm_p7) << 1;
        for (int k = 0; k < 3; k++) begin
            w_num[k]    = (WR'(r_m_p7[k]) << 1) + WR'(r_dm_p7);
            n_rem_p8[k] = w_num[k];
            n_ovf_p8[k] = w_num[k] >= (n_den_p8 << QB);
        end
        for (int j = 0; j < NCH; j++) begin
            n_np_p8[j] = WNP'(r_sq2_p7[0][j*WH +: WH]) * WNP'(r_d2_p7);
        end
    end

    // ---------------- stage 9: radicand 4*Q^2*|d|^2
    logic [WN-1:0]  n_n_p9, r_n_p9;
    logic [WR-1:0]  r_rem_p9 [3];
    logic [WR-1:0]  r_den_p9;
    logic [2:0]     r_ovf_p9, r_neg_p9;
    logic [WSQ-1:0] r_dsq_p9;
    logic           r_hit_p9;
    t_coord         r_o_p9 [3];

    always_comb begin
        n_n_p9 = '0;
        for (int j = 0; j < NCH; j++) begin
            n_n_p9 = n_n_p9 + (WN'(r_np_p8[j]) << (j * WH));
        end
        n_n_p9 = n_n_p9 << 2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_p1  <= n_e1_p1;   r_e2_p1 <= n_e2_p1;   r_df_p1 <= n_df_p1;
            r_o_p1   <= w_in_o;    r_d_p1  <= w_in_d;

            r_pa_p2  <= n_pa_p2;   r_pb_p2 <= n_pb_p2;   r_df_p2 <= r_df_p1;
            r_o_p2   <= r_o_p1;    r_d_p2  <= r_d_p1;    r_dd_p2 <= n_dd_p2;

            r_pd_p3  <= n_pd_p3;   r_d2_p3 <= n_d2_p3;
            r_o_p3   <= r_o_p2;    r_d_p3  <= r_d_p2;

            r_s_p4   <= n_s_p4;    r_d2_p4 <= r_d2_p3;
            r_o_p4   <= r_o_p3;    r_d_p4  <= r_d_p3;

            r_hit_p5 <= n_hit_p5;  r_qm_p5 <= n_qm_p5;   r_dm_p5 <= n_dm_p5;
            r_d2_p5  <= r_d2_p4;   r_o_p5  <= r_o_p4;    r_d_p5  <= r_d_p4;

            r_pml_p6 <= n_pml_p6;  r_pmh_p6 <= n_pmh_p6; r_sq_p6 <= n_sq_p6;
            r_dm_p6  <= r_dm_p5;   r_neg_p6 <= n_neg_p6; r_hit_p6 <= r_hit_p5;
            r_d2_p6  <= r_d2_p5;   r_o_p6   <= r_o_p5;

            r_m_p7   <= n_m_p7;    r_sq2_p7 <= n_sq2_p7; r_dm_p7 <= r_dm_p6;
            r_neg_p7 <= r_neg_p6;  r_hit_p7 <= r_hit_p6; r_d2_p7 <= r_d2_p6;
            r_o_p7   <= r_o_p6;

            r_rem_p8 <= n_rem_p8;  r_den_p8 <= n_den_p8; r_ovf_p8 <= n_ovf_p8;
            r_np_p8  <= n_np_p8;   r_dsq_p8 <= r_sq2_p7[1];
            r_neg_p8 <= r_neg_p7;  r_hit_p8 <= r_hit_p7; r_o_p8   <= r_o_p7;

            r_n_p9   <= n_n_p9;    r_rem_p9 <= r_rem_p8; r_den_p9 <= r_den_p8;
            r_ovf_p9 <= r_ovf_p8;  r_neg_p9 <= r_neg_p8; r_dsq_p9 <= r_dsq_p8;
            r_hit_p9 <= r_hit_p8;  r_o_p9   <= r_o_p8;
        end
    end

    // ---------------- iterations: one root bit a stage, one quotient bit in each of the first QB stages
    t_iter w_it0;
    t_iter r_it [NIT];

    always_comb begin
        w_it0     = '0;
        w_it0.hit = r_hit_p9;
        w_it0.neg = r_neg_p9;
        w_it0.ovf = r_ovf_p9;
        w_it0.den = r_den_p9;
        w_it0.r   = r_n_p9;
        w_it0.dsq = r_dsq_p9;
        for (int k = 0; k < 3; k++) begin
            w_it0.o[k]   = r_o_p9[k];
            w_it0.rem[k] = r_rem_p9[k];
        end
    end

    for (genvar i = 0; i < NIT; i++) begin : g_it
        localparam bit DIV_ON = (i < QB);
        localparam int BD     = DIV_ON ? (QB - 1 - i) : 0;
        localparam int BS     = SB - 1 - i;

        t_iter         w_prev, w_next;
        logic [WR-1:0] w_dsh;
        logic [WN-1:0] w_term;

        if (i == 0) begin : g_first
            assign w_prev = w_it0;
        end else begin : g_rest
            assign w_prev = r_it[i-1];
        end

        always_comb begin
            w_next = w_prev;
            w_dsh  = w_prev.den << BD;
            if (DIV_ON) begin
                for (int k = 0; k < 3; k++) begin
                    if (w_prev.rem[k] >= w_dsh) begin
                        w_next.rem[k]     = w_prev.rem[k] - w_dsh;
                        w_next.quo[k][BD] = 1'b1;
                    end
                end
            end
            // (s + 2^b)^2 D^2 <= N  <=>  (2 s D^2) 2^b + D^2 4^b <= N - s^2 D^2
            w_term = (w_prev.sd << (BS + 1)) + (WN'(w_prev.dsq) << (2 * BS));
            if (w_term <= w_prev.r) begin
                w_next.r     = w_prev.r - w_term;
                w_next.sd    = w_prev.sd + (WN'(w_prev.dsq) << BS);
                w_next.s[BS] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) r_it[i] <= w_next;
        end
    end

    // ---------------- output: sign, round-off, saturation
    localparam int PMAX = 2 ** (CB - 1) - 1;
    localparam int DMAX = 2 ** CB - 1;

    t_iter         w_last;
    t_pt           w_mag [3], w_sum [3];
    logic [CB-1:0] w_pt [3];
    logic [SB:0]   w_sr;
    logic [CB-1:0] w_dist;
    logic [OUT_W-1:0] n_out_tdata;

    always_comb begin
        w_last = r_it[NIT-1];
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = t_pt'({2'b00, w_last.quo[k]});
            w_sum[k] = t_pt'(t_coord'(w_last.o[k]))
                     + (w_last.neg[k] ? -w_mag[k] : w_mag[k]);
            if (w_last.ovf[k]) begin
                w_pt[k] = w_last.neg[k] ? CB'(-PMAX - 1) : CB'(PMAX);
            end else if (w_sum[k] > t_pt'(PMAX)) begin
                w_pt[k] = CB'(PMAX);
            end else if (w_sum[k] < t_pt'(-PMAX - 1)) begin
                w_pt[k] = CB'(-PMAX - 1);
            end else begin
                w_pt[k] = w_sum[k][CB-1:0];
            end
        end
        w_sr   = ({1'b0, w_last.s} + (SB+1)'(1)) >> 1;
        w_dist = (w_sr > (SB+1)'(DMAX)) ? CB'(DMAX) : w_sr[CB-1:0];
        if (w_last.hit) begin
            n_out_tdata = OUT_W'({w_dist, w_pt[2], w_pt[1], w_pt[0]});
        end else begin
            n_out_tdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_tdata <= n_out_tdata;
            r_out_hit   <= w_last.hit;
        end
    end

    // ---------------- checks
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss beat carries non-zero payload");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v[0])
        else $error("accepted ray not captured in first stage");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && (r_v == '0))
        else $error("stage valid left set by reset");

endmodule
